### sv/utv_pkg.sv
// shared types and constants for the utf-8 text validator
package utv_pkg;

  // verdict codes carried in the status field
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SPACE     = 3'd2,
    ST_CONTROL   = 3'd3,
    ST_MALFORMED = 3'd4,
    ST_FORBIDDEN = 3'd5
  } status_t;

  localparam int CP_W = 21;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] DEL_BYTE   = 8'h7f;

  localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h0d800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h0dfff;
  localparam logic [CP_W-1:0] C1_LO       = 21'h00080;
  localparam logic [CP_W-1:0] C1_HI       = 21'h0009f;
  localparam logic [CP_W-1:0] LINE_SEP    = 21'h02028;
  localparam logic [CP_W-1:0] PARA_SEP    = 21'h02029;

  // per-string tracking state
  typedef struct packed {
    logic [1:0]      expected;
    logic [CP_W-1:0] cp;
    logic [1:0]      cls;
    status_t         fault;
    logic            seen;
    logic            start_sp;
    logic            end_sp;
  } str_state_t;

  localparam str_state_t STR_CLEAR = '{
    expected: 2'd0, cp: '0, cls: 2'd0, fault: ST_OK,
    seen: 1'b0, start_sp: 1'b0, end_sp: 1'b0
  };

endpackage

### sv/utv_byte_step.sv
// next per-string state after one data byte
module utv_byte_step
  import utv_pkg::*;
(
  input  str_state_t cur,
  input  logic [7:0] data_byte,
  output str_state_t nxt
);

  logic [CP_W-1:0] cp_cont;
  logic [CP_W-1:0] cp_min;
  status_t         judge;

  assign cp_cont = {cur.cp[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    case (cur.cls)
      2'd1:    cp_min = CP_MIN_2B;
      2'd2:    cp_min = CP_MIN_3B;
      default: cp_min = CP_MIN_4B;
    endcase
  end

  always_comb begin
    if (cp_cont < cp_min) begin
      judge = ST_MALFORMED;
    end else if (cp_cont > CP_MAX ||
                 (cp_cont >= SURR_LO && cp_cont <= SURR_HI) ||
                 (cp_cont >= C1_LO && cp_cont <= C1_HI) ||
                 cp_cont == LINE_SEP || cp_cont == PARA_SEP) begin
      judge = ST_FORBIDDEN;
    end else begin
      judge = ST_OK;
    end
  end

  always_comb begin
    nxt = cur;
    // edge space tracking runs even after a fault
    if (!cur.seen) begin
      nxt.start_sp = (data_byte == SPACE_BYTE);
    end
    nxt.seen   = 1'b1;
    nxt.end_sp = (data_byte == SPACE_BYTE);

    if (cur.fault == ST_OK) begin
      if (cur.expected == 2'd0) begin
        if (data_byte inside {[8'h00:8'h1f], DEL_BYTE}) begin
          nxt.fault = ST_CONTROL;
        end else if (data_byte inside {[8'h20:8'h7e]}) begin
          nxt.fault = ST_OK;
        end else if (data_byte inside {[8'hc2:8'hdf]}) begin
          nxt.expected = 2'd1;
          nxt.cls      = 2'd1;
          nxt.cp       = {16'd0, data_byte[4:0]};
        end else if (data_byte inside {[8'he0:8'hef]}) begin
          nxt.expected = 2'd2;
          nxt.cls      = 2'd2;
          nxt.cp       = {17'd0, data_byte[3:0]};
        end else if (data_byte inside {[8'hf0:8'hf4]}) begin
          nxt.expected = 2'd3;
          nxt.cls      = 2'd3;
          nxt.cp       = {18'd0, data_byte[2:0]};
        end else begin
          nxt.fault = ST_MALFORMED;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        nxt.fault    = ST_MALFORMED;
        nxt.expected = 2'd0;
      end else begin
        nxt.cp       = cp_cont;
        nxt.expected = cur.expected - 2'd1;
        if (cur.expected == 2'd1) begin
          nxt.fault = judge;
        end
      end
    end
  end

endmodule

### sv/utv_verdict.sv
// verdict for a string at its end transfer
module utv_verdict
  import utv_pkg::*;
(
  input  str_state_t cur,
  input  logic       text_required,
  output status_t    status
);

  always_comb begin
    if (text_required && !cur.seen) begin
      status = ST_EMPTY;
    end else if (cur.seen && (cur.start_sp || cur.end_sp)) begin
      status = ST_SPACE;
    end else if (cur.fault != ST_OK) begin
      status = cur.fault;
    end else if (cur.expected != 2'd0) begin
      status = ST_MALFORMED;
    end else begin
      status = ST_OK;
    end
  end

endmodule

### sv/utf8_text_validator_top.sv
// top level of the single-line utf-8 text validator
//
// input stream: one transfer per string byte (in_tuser = 0) and one closing
// transfer per string (in_tuser = 1, in_tdata ignored)
// output stream: one verdict transfer per closing transfer; byte transfers
// give no output
// cfg_we / cfg_wdata set text_required (an empty string is rejected when 1);
// write it only while no string is in flight
//
// throughput: one input transfer per cycle, set by the single register
// stage that holds the per-string state and the output register
// latency: the verdict shows on out_tvalid one cycle after the closing
// transfer
// when the receiver stalls the verdict holds in the output register;
// byte transfers keep flowing only while the output register is free
// or being drained in the same cycle
// reset: per-string state clears, text_required returns to 0, the output
// register empties and in_tready stays low until the cycle after reset
module utf8_text_validator_top
  import utv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] kind: 0 byte, 1 end of string
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] valid_res, [3:1] status, [7:4] zero
);

  logic       text_required_r;
  logic       live_r;
  str_state_t str_r, str_nxt, str_step;
  status_t    verdict;
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic       in_xfer;
  logic       end_xfer;
  logic       out_free;

  // output register is free when empty or drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = live_r && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign end_xfer  = in_xfer && in_tuser;

  utv_byte_step u_step (
    .cur       (str_r),
    .data_byte (in_tdata),
    .nxt       (str_step)
  );

  utv_verdict u_verdict (
    .cur           (str_r),
    .text_required (text_required_r),
    .status        (verdict)
  );

  // per-string state: byte transfers advance it, closing transfer clears it
  always_comb begin
    str_nxt = str_r;
    if (in_xfer) begin
      str_nxt = in_tuser ? STR_CLEAR : str_step;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (end_xfer) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_required_r <= 1'b0;
      live_r          <= 1'b0;
      str_r           <= STR_CLEAR;
      out_valid_r     <= 1'b0;
    end else begin
      live_r      <= 1'b1;
      str_r       <= str_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        text_required_r <= cfg_wdata;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_status_r, (out_status_r == ST_OK)};

endmodule

### sv/utv_checker.sv
// port-level checks for the utf-8 text validator, bound to the top level
module utv_checker
  import utv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled verdict changed");

  // valid flag agrees with the status code
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (out_tdata[3:1] == ST_OK))
    else $error("valid_res disagrees with status");

  // status stays within the defined codes
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:1] <= ST_FORBIDDEN && out_tdata[7:4] == 4'd0)
    else $error("undefined status code");

  // a new verdict only follows a closing transfer
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser))
    else $error("verdict without end of string");

endmodule

bind utf8_text_validator_top utv_checker u_utv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### sim/tb_utf8_text_validator_top.sv
// self-checking testbench for the utf-8 text validator top level
`timescale 1ns / 1ps

module tb_utf8_text_validator_top;
  import utv_pkg::*;

  // cycles of the long receiver hold-off and the no-transfer watchdog
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  // items per random phase and number of phases
  localparam int PHASE_ITEMS    = 100;
  localparam int PHASES         = 7;

  // kinds of directed stimulus rows
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_END,
    ROW_CFG
  } row_act_t;

  typedef struct {
    row_act_t   act;
    logic [7:0] val;    // string byte, or register value for a config row
    logic       typed;  // verdict given in the row instead of predicted
    status_t    st;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tuser;   // [0] kind: 0 byte, 1 end of string
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] valid_res, [3:1] status, [7:4] zero

  // verdicts still owed by the block, oldest first
  status_t    verdict_q[$];
  stim_row_t  dir_rows[$];
  logic [7:0] str_bytes[$];

  int err_count     = 0;
  int sent_items    = 0;
  int verdicts_seen = 0;
  int quiet_cycles  = 0;
  logic no_idle     = 1'b0;

  // predictor copy of the block's per-string state and its register
  logic [1:0]  cont_due;
  logic [20:0] cp_acc;
  logic [1:0]  seq_cls;
  status_t     first_err;
  logic        seen_any;
  logic        lead_space;
  logic        tail_space;
  logic        empty_rejected;

  utf8_text_validator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void forget_string();
    cont_due   = 2'd0;
    cp_acc     = '0;
    seq_cls    = 2'd0;
    first_err  = ST_OK;
    seen_any   = 1'b0;
    lead_space = 1'b0;
    tail_space = 1'b0;
  endfunction

  // one string byte into the tracking state
  function automatic void absorb_byte(input logic [7:0] b);
    logic [20:0] min_cp;
    if (!seen_any) lead_space = (b == SPACE_BYTE);
    seen_any   = 1'b1;
    tail_space = (b == SPACE_BYTE);
    // once faulted only the edge-space tracking moves
    if (first_err != ST_OK) return;
    if (cont_due == 2'd0) begin
      if (b < SPACE_BYTE || b == DEL_BYTE) begin
        first_err = ST_CONTROL;
      end else if (b < 8'h80) begin
        // printable ascii
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        cont_due = 2'd1; seq_cls = 2'd1; cp_acc = {16'd0, b[4:0]};
      end else if (b >= 8'he0 && b <= 8'hef) begin
        cont_due = 2'd2; seq_cls = 2'd2; cp_acc = {17'd0, b[3:0]};
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        cont_due = 2'd3; seq_cls = 2'd3; cp_acc = {18'd0, b[2:0]};
      end else begin
        // continuation byte, c0/c1 or f5..ff in lead position
        first_err = ST_MALFORMED;
      end
      return;
    end
    // a continuation is due: anything but 10xxxxxx breaks the sequence
    if (b[7:6] != 2'b10) begin
      first_err = ST_MALFORMED;
      cont_due  = 2'd0;
      return;
    end
    cp_acc   = {cp_acc[14:0], b[5:0]};
    cont_due = cont_due - 2'd1;
    if (cont_due == 2'd0) begin
      min_cp = (seq_cls == 2'd1) ? CP_MIN_2B : (seq_cls == 2'd2) ? CP_MIN_3B : CP_MIN_4B;
      if (cp_acc < min_cp)
        first_err = ST_MALFORMED;
      else if (cp_acc > CP_MAX || (cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
               (cp_acc >= C1_LO && cp_acc <= C1_HI) ||
               cp_acc == LINE_SEP || cp_acc == PARA_SEP)
        first_err = ST_FORBIDDEN;
      else
        first_err = ST_OK;
    end
  endfunction

  // verdict of the string at its closing transfer, priority empty first
  function automatic status_t close_string();
    status_t v;
    if (empty_rejected && !seen_any)           v = ST_EMPTY;
    else if (seen_any && (lead_space || tail_space)) v = ST_SPACE;
    else if (first_err != ST_OK)               v = first_err;
    else if (cont_due != 2'd0)                 v = ST_MALFORMED;  // truncated
    else                                       v = ST_OK;
    forget_string();
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_row(input row_act_t a, input logic [7:0] v,
                                  input logic typed, input status_t st);
    stim_row_t row;
    row.act   = a;
    row.val   = v;
    row.typed = typed;
    row.st    = st;
    dir_rows.push_back(row);
  endfunction

  // shortest utf-8 length of a code point
  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80)    return 1;
    if (cp < 21'h800)   return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // random code point of the range a given length encodes without overlong
  function automatic logic [20:0] rand_cp(input int len);
    case (len)
      2:       return 21'($urandom_range(21'h80, 21'h7ff));
      3:       return 21'($urandom_range(21'h800, 21'hffff));
      default: return 21'($urandom_range(21'h10000, 21'h10ffff));
    endcase
  endfunction

  // encode a code point in len bytes, longer than needed gives overlong forms
  function automatic void push_cp(input logic [20:0] cp, input int len);
    case (len)
      1: str_bytes.push_back(cp[7:0]);
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // offer one input item and wait for its transfer, then predict it
  task automatic send_item(input logic kind, input logic [7:0] b,
                           input logic typed, input status_t typed_st);
    int gap;
    status_t v;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (!kind) begin
      absorb_byte(b);
    end else begin
      v = close_string();
      if (typed) v = typed_st;
      verdict_q.push_back(v);
    end
  endtask

  // register write once the block has drained
  task automatic set_required(input logic v);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    empty_rejected = v;
  endtask

  // one random string: mostly well formed, some mixed faults, some noise
  task automatic send_string();
    int mode;
    int nchar;
    int r;
    int len;
    logic [20:0] cp;
    logic [7:0] b;
    str_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      // raw noise bytes
      nchar = $urandom_range(1, 8);
      repeat (nchar) str_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      nchar = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
      repeat (nchar) begin
        // clean strings draw only printable ascii and in-range sequences
        r = (mode < 70) ? $urandom_range(0, 62) : $urandom_range(0, 99);
        if (r < 35) begin
          str_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
        end else if (r < 63) begin
          len = (r < 45) ? 2 : (r < 55) ? 3 : 4;
          push_cp(rand_cp(len), len);
        end else if (r < 70) begin
          // boundary and forbidden code points in their natural length
          case ($urandom_range(0, 17))
            0:  cp = 21'h80;
            1:  cp = 21'h9f;
            2:  cp = 21'ha0;
            3:  cp = 21'h7ff;
            4:  cp = 21'h800;
            5:  cp = 21'hd7ff;
            6:  cp = SURR_LO;
            7:  cp = SURR_HI;
            8:  cp = 21'he000;
            9:  cp = 21'h2027;
            10: cp = LINE_SEP;
            11: cp = PARA_SEP;
            12: cp = 21'h202a;
            13: cp = 21'hffff;
            14: cp = CP_MIN_4B;
            15: cp = CP_MAX;
            16: cp = 21'h110000;
            default: cp = 21'h1fffff;
          endcase
          push_cp(cp, natural_len(cp));
        end else if (r < 76) begin
          // overlong form
          cp = 21'($urandom_range(0, 21'hffff));
          push_cp(cp, $urandom_range(natural_len(cp) + 1, 4));
        end else if (r < 80) begin
          str_bytes.push_back(SPACE_BYTE);
        end else if (r < 84) begin
          b = 8'($urandom_range(0, 32));
          str_bytes.push_back((b == 8'd32) ? DEL_BYTE : b);
        end else if (r < 88) begin
          // truncated sequence
          len = $urandom_range(2, 4);
          push_cp(rand_cp(len), len);
          void'(str_bytes.pop_back());
        end else if (r < 93) begin
          str_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          // broken continuation
          len = $urandom_range(2, 4);
          push_cp(rand_cp(len), len);
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          str_bytes[$] = b;
        end
      end
    end
    foreach (str_bytes[i]) send_item(1'b0, str_bytes[i], 1'b0, ST_OK);
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, ST_OK);
  endtask

  // ---------------------------------------------------------------------
  // sender: reset, directed table, random phases, drain
  // ---------------------------------------------------------------------

  initial begin : sender
    int phase_start;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    empty_rejected = 1'b0;
    forget_string();

    // directed table, verdicts typed in where they follow at a glance
    add_row(ROW_END,  8'h00, 1'b1, ST_OK);         // empty, not required
    add_row(ROW_CFG,  8'h01, 1'b0, ST_OK);
    add_row(ROW_END,  8'hff, 1'b1, ST_EMPTY);      // empty, required
    add_row(ROW_BYTE, 8'h20, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b1, ST_SPACE);      // lone space
    add_row(ROW_BYTE, 8'h7f, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b1, ST_CONTROL);    // delete byte
    add_row(ROW_BYTE, 8'hff, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b1, ST_MALFORMED);  // bad lead at top value
    add_row(ROW_BYTE, 8'he0, 1'b0, ST_OK);         // overlong zero
    add_row(ROW_BYTE, 8'h80, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'h80, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'he2, 1'b0, ST_OK);         // truncated sequence
    add_row(ROW_BYTE, 8'h80, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b1, ST_MALFORMED);
    add_row(ROW_BYTE, 8'hc3, 1'b0, ST_OK);         // control byte as continuation
    add_row(ROW_BYTE, 8'h1f, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b1, ST_MALFORMED);
    add_row(ROW_BYTE, 8'hf4, 1'b0, ST_OK);         // highest legal code point
    add_row(ROW_BYTE, 8'h8f, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'hbf, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'hbf, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'hf4, 1'b0, ST_OK);         // one past the top
    add_row(ROW_BYTE, 8'h90, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'h80, 1'b0, ST_OK);
    add_row(ROW_BYTE, 8'h80, 1'b0, ST_OK);
    add_row(ROW_END,  8'h00, 1'b0, ST_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].act)
        ROW_CFG:  set_required(dir_rows[i].val[0]);
        ROW_BYTE: send_item(1'b0, dir_rows[i].val, 1'b0, ST_OK);
        default:  send_item(1'b1, 8'($urandom_range(0, 255)),
                            dir_rows[i].typed, dir_rows[i].st);
      endcase
    end

    // random phases, the register alternates and one phase runs back to back
    for (int p = 0; p < PHASES; p++) begin
      set_required(1'(p % 2));
      no_idle = (p == 3);
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) send_string();
    end

    // drain, then allow the output latency before the verdict
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // receiver: random ready with two long hold-offs
  // ---------------------------------------------------------------------

  initial begin : receiver
    int gap;
    int run;
    int holds_done;
    int hold_at;
    out_tready = 1'b0;
    holds_done = 0;
    hold_at    = 40;
    @(posedge clk);
    forever begin
      if (holds_done < 2 && verdicts_seen >= hold_at) begin
        // long hold so the output register fills and the input backs up
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
        hold_at += 30;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // output check against the oldest owed verdict
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : verdict_check
    status_t want;
    logic    want_ok;
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_seen <= verdicts_seen + 1;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict transfer, expected none, actual tdata %h",
                 $time, out_tdata);
        err_count++;
      end else begin
        want    = verdict_q.pop_front();
        want_ok = (want == ST_OK);
        if (out_tdata[0] !== want_ok) begin
          $display("%0t: valid_res mismatch, expected %0d, actual %0d",
                   $time, want_ok, out_tdata[0]);
          err_count++;
        end
        if (out_tdata[3:1] !== want) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want, out_tdata[3:1]);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

### utf8_text_validator_top.f
sv/utv_pkg.sv
sv/utv_byte_step.sv
sv/utv_verdict.sv
sv/utf8_text_validator_top.sv
sv/utv_checker.sv
sim/tb_utf8_text_validator_top.sv
